// ===== rtl/bsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bsa_pkg;

    localparam int RESOURCES_DEF  = 4;
    localparam int PROCESSES_DEF  = 8;
    localparam int COUNT_BITS_DEF = 8;

    localparam logic [2:0] RES_COUNT_RST  = 3'd4;
    localparam logic [3:0] PROC_COUNT_RST = 4'd8;

    localparam logic [0:0] CFG_RES_COUNT  = 1'b0;
    localparam logic [0:0] CFG_PROC_COUNT = 1'b1;

    localparam logic [2:0] ACT_SET_FREE   = 3'd0;
    localparam logic [2:0] ACT_LOAD_MAX   = 3'd1;
    localparam logic [2:0] ACT_LOAD_ALLOC = 3'd2;
    localparam logic [2:0] ACT_REQUEST    = 3'd3;
    localparam logic [2:0] ACT_CHECK      = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BAD    = 3'd1;
    localparam logic [2:0] ST_NEED   = 3'd2;
    localparam logic [2:0] ST_AVAIL  = 3'd3;
    localparam logic [2:0] ST_ROLLED = 3'd4;
    localparam logic [2:0] ST_UNSAFE = 3'd5;
    localparam logic [2:0] ST_REJECT = 3'd6;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DEC,
        S_LD_RD,
        S_LD_CHK,
        S_CHK_RD,
        S_CHK_CMP,
        S_GR_RD,
        S_GR_WR,
        S_SC_INIT,
        S_ROW,
        S_ROW_RD,
        S_ROW_CMP,
        S_ROW_END,
        S_RB_RD,
        S_RB_WR,
        S_EMIT,
        S_STREAM
    } bsa_state_t;

    typedef struct packed {
        logic       in_ready;
        logic       clr_step;
        logic       wr_free;
        logic       load_max;
        logic       addr_item_r;
        logic       addr_scan;
        logic       ld_commit;
        logic       buf_write;
        logic       buf_clear;
        logic       r_zero;
        logic       r_inc;
        logic       grant_wr;
        logic       roll_wr;
        logic       scan_init;
        logic       row_start;
        logic       row_cmp;
        logic       row_commit;
        logic       p_inc;
        logic       emit;
        logic       seq_out;
        logic       j_zero;
        logic       j_inc;
        logic [2:0] emit_status;
    } bsa_cmd_t;

    typedef struct packed {
        logic       in_fire;
        logic [2:0] act;
        logic       p_ok;
        logic       r_ok;
        logic       last;
        logic       clr_done;
        logic       r_last;
        logic       p_last;
        logic       k_last;
        logic       fits;
        logic       need_bad;
        logic       avail_bad;
        logic       ld_reject;
        logic       fin_p;
        logic       j_last;
        logic       out_space;
    } bsa_sts_t;

endpackage
`default_nettype wire

// ===== rtl/bsa_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bsa_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [2:0] process;
    logic [1:0] resource;
    logic [7:0] amount;
    logic       last;

    modport source (output valid, action, process, resource, amount, last, input ready);
    modport sink (input valid, action, process, resource, amount, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/bsa_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bsa_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] sequence_process;
    logic       end_of_run;

    modport source (output valid, status, sequence_process, end_of_run, input ready);
    modport sink (input valid, status, sequence_process, end_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/bsa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== rtl/bsa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bsa_pkg::bsa_sts_t sts,
    output bsa_pkg::bsa_cmd_t      cmd
);
    import bsa_pkg::*;

    bsa_state_t state_reg, state_next;
    logic [2:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        code_next       = code_reg;
        cmd             = '0;
        cmd.emit_status = code_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_fire)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.addr_item_r = 1'b1;
                state_next      = S_EMIT;
                case (sts.act)
                    ACT_SET_FREE:
                    begin
                        cmd.wr_free = sts.r_ok;
                        code_next   = sts.r_ok ? ST_OK : ST_BAD;
                    end
                    ACT_LOAD_MAX:
                    begin
                        cmd.load_max = sts.r_ok && sts.p_ok;
                        code_next    = (sts.r_ok && sts.p_ok) ? ST_OK : ST_BAD;
                    end
                    ACT_LOAD_ALLOC:
                    begin
                        if (sts.r_ok && sts.p_ok)
                        begin
                            state_next = S_LD_RD;
                        end
                        else
                        begin
                            code_next = ST_BAD;
                        end
                    end
                    ACT_REQUEST:
                    begin
                        if (!sts.r_ok)
                        begin
                            cmd.buf_clear = 1'b1;
                            code_next     = ST_BAD;
                        end
                        else
                        begin
                            cmd.buf_write = 1'b1;
                            if (!sts.last)
                            begin
                                state_next = S_IDLE;
                            end
                            else if (!sts.p_ok)
                            begin
                                cmd.buf_clear = 1'b1;
                                code_next     = ST_BAD;
                            end
                            else
                            begin
                                cmd.r_zero = 1'b1;
                                state_next = S_CHK_RD;
                            end
                        end
                    end
                    ACT_CHECK:
                    begin
                        state_next = S_SC_INIT;
                    end
                    default:
                    begin
                        code_next = ST_BAD;
                    end
                endcase
            end
            S_LD_RD:
            begin
                cmd.addr_item_r = 1'b1;
                state_next      = S_LD_CHK;
            end
            S_LD_CHK:
            begin
                cmd.addr_item_r = 1'b1;
                cmd.ld_commit   = !sts.ld_reject;
                code_next       = sts.ld_reject ? ST_REJECT : ST_OK;
                state_next      = S_EMIT;
            end
            S_CHK_RD:
            begin
                state_next = S_CHK_CMP;
            end
            S_CHK_CMP:
            begin
                if (sts.need_bad || sts.avail_bad)
                begin
                    cmd.buf_clear = 1'b1;
                    code_next     = sts.need_bad ? ST_NEED : ST_AVAIL;
                    state_next    = S_EMIT;
                end
                else if (sts.r_last)
                begin
                    cmd.r_zero = 1'b1;
                    state_next = S_GR_RD;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = S_CHK_RD;
                end
            end
            S_GR_RD:
            begin
                state_next = S_GR_WR;
            end
            S_GR_WR:
            begin
                cmd.grant_wr = 1'b1;
                if (sts.r_last)
                begin
                    state_next = S_SC_INIT;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = S_GR_RD;
                end
            end
            S_SC_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_ROW;
            end
            S_ROW:
            begin
                if (sts.fin_p)
                begin
                    if (sts.p_last)
                    begin
                        if (sts.act == ACT_REQUEST)
                        begin
                            cmd.r_zero = 1'b1;
                            state_next = S_RB_RD;
                        end
                        else
                        begin
                            code_next  = ST_UNSAFE;
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        cmd.p_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.r_zero    = 1'b1;
                    cmd.row_start = 1'b1;
                    state_next    = S_ROW_RD;
                end
            end
            S_ROW_RD:
            begin
                cmd.addr_scan = 1'b1;
                state_next    = S_ROW_CMP;
            end
            S_ROW_CMP:
            begin
                cmd.row_cmp = 1'b1;
                if (sts.r_last)
                begin
                    state_next = S_ROW_END;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = S_ROW_RD;
                end
            end
            S_ROW_END:
            begin
                if (sts.fits)
                begin
                    cmd.row_commit = 1'b1;
                    if (sts.k_last)
                    begin
                        cmd.buf_clear = (sts.act == ACT_REQUEST);
                        cmd.j_zero    = 1'b1;
                        state_next    = S_STREAM;
                    end
                    else
                    begin
                        state_next = S_ROW;
                    end
                end
                else if (sts.p_last)
                begin
                    if (sts.act == ACT_REQUEST)
                    begin
                        cmd.r_zero = 1'b1;
                        state_next = S_RB_RD;
                    end
                    else
                    begin
                        code_next  = ST_UNSAFE;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = S_ROW;
                end
            end
            S_RB_RD:
            begin
                state_next = S_RB_WR;
            end
            S_RB_WR:
            begin
                cmd.roll_wr = 1'b1;
                if (sts.r_last)
                begin
                    cmd.buf_clear = 1'b1;
                    code_next     = ST_ROLLED;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = S_RB_RD;
                end
            end
            S_EMIT:
            begin
                if (sts.out_space)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_STREAM:
            begin
                if (sts.out_space)
                begin
                    cmd.seq_out = 1'b1;
                    if (sts.j_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.j_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/bsa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsa_dp #(
    parameter int RESOURCES  = 4,
    parameter int PROCESSES  = 8,
    parameter int COUNT_BITS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [3:0]        cfg_data,
    bsa_in_if.sink                 item,
    bsa_out_if.source              result,
    input  wire bsa_pkg::bsa_cmd_t cmd,
    output bsa_pkg::bsa_sts_t      sts
);
    import bsa_pkg::*;

    localparam int CB     = COUNT_BITS;
    localparam int CMAX   = (1 << COUNT_BITS) - 1;
    localparam int RW     = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int PW     = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int RCW    = $clog2(RESOURCES + 1);
    localparam int PCW    = $clog2(PROCESSES + 1);
    localparam int DEPTH  = PROCESSES * RESOURCES;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CB] ? {CB{1'b1}} : s[CB-1:0];
    endfunction

    // configuration
    logic [2:0]   res_cfg_reg;
    logic [3:0]   proc_cfg_reg;
    logic [RCW-1:0] nr;
    logic [PCW-1:0] np;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cfg_reg  <= RES_COUNT_RST;
            proc_cfg_reg <= PROC_COUNT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RES_COUNT)
            begin
                res_cfg_reg <= cfg_data[2:0];
            end
            else
            begin
                proc_cfg_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (res_cfg_reg == 3'd0)
        begin
            nr = RCW'(1);
        end
        else if (32'(res_cfg_reg) > RESOURCES)
        begin
            nr = RCW'(RESOURCES);
        end
        else
        begin
            nr = RCW'(res_cfg_reg);
        end
        if (proc_cfg_reg == 4'd0)
        begin
            np = PCW'(1);
        end
        else if (32'(proc_cfg_reg) > PROCESSES)
        begin
            np = PCW'(PROCESSES);
        end
        else
        begin
            np = PCW'(proc_cfg_reg);
        end
    end

    // latched word
    logic          in_fire;
    logic [2:0]    act_reg;
    logic [PW-1:0] item_p_reg;
    logic [RW-1:0] item_r_reg;
    logic [CB-1:0] amt_reg;
    logic          p_ok_reg, r_ok_reg, last_reg;

    assign item.ready = cmd.in_ready;
    assign in_fire    = item.valid && cmd.in_ready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg    <= item.action;
            item_p_reg <= PW'(item.process);
            item_r_reg <= RW'(item.resource);
            amt_reg    <= (32'(item.amount) > CMAX) ? CB'(CMAX) : CB'(item.amount);
            p_ok_reg   <= 32'(item.process) < 32'(np);
            r_ok_reg   <= 32'(item.resource) < 32'(nr);
            last_reg   <= item.last;
        end
    end

    // counters
    logic [RW-1:0]  r_cnt_reg;
    logic [PW-1:0]  p_cnt_reg;
    logic [PCW-1:0] k_reg;
    logic [PW-1:0]  j_reg;
    logic [AW-1:0]  clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_cnt_reg   <= '0;
            p_cnt_reg   <= '0;
            k_reg       <= '0;
            j_reg       <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.r_zero)
            begin
                r_cnt_reg <= '0;
            end
            else if (cmd.r_inc)
            begin
                r_cnt_reg <= r_cnt_reg + RW'(1);
            end
            if (cmd.scan_init || cmd.row_commit)
            begin
                p_cnt_reg <= '0;
            end
            else if (cmd.p_inc)
            begin
                p_cnt_reg <= p_cnt_reg + PW'(1);
            end
            if (cmd.scan_init)
            begin
                k_reg <= '0;
            end
            else if (cmd.row_commit)
            begin
                k_reg <= k_reg + PCW'(1);
            end
            if (cmd.j_zero)
            begin
                j_reg <= '0;
            end
            else if (cmd.j_inc)
            begin
                j_reg <= j_reg + PW'(1);
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // need / allocation memories
    logic [PW-1:0] p_sel;
    logic [RW-1:0] r_sel;
    logic [AW-1:0] addr;
    logic          mem_we;
    logic [CB-1:0] need_rd, alloc_rd, need_wd, alloc_wd;
    logic [CB-1:0] free_reg [RESOURCES];
    logic [CB-1:0] buf_reg  [RESOURCES];
    logic [CB-1:0] buf_r, free_r;

    assign p_sel  = cmd.addr_scan ? p_cnt_reg : item_p_reg;
    assign r_sel  = cmd.addr_item_r ? item_r_reg : r_cnt_reg;
    assign addr   = cmd.clr_step ? clr_cnt_reg
                  : AW'(AW'(p_sel) * AW'(RESOURCES) + AW'(r_sel));
    assign mem_we = cmd.clr_step || cmd.load_max || cmd.ld_commit
                  || cmd.grant_wr || cmd.roll_wr;
    assign buf_r  = buf_reg[r_cnt_reg];
    assign free_r = free_reg[r_cnt_reg];

    always_comb
    begin
        need_wd  = '0;
        alloc_wd = '0;
        if (cmd.load_max)
        begin
            need_wd = amt_reg;
        end
        else if (cmd.ld_commit)
        begin
            need_wd  = need_rd - amt_reg;
            alloc_wd = sat_add(alloc_rd, amt_reg);
        end
        else if (cmd.grant_wr)
        begin
            need_wd  = need_rd - buf_r;
            alloc_wd = sat_add(alloc_rd, buf_r);
        end
        else if (cmd.roll_wr)
        begin
            need_wd  = need_rd + buf_r;
            alloc_wd = (alloc_rd < buf_r) ? '0 : alloc_rd - buf_r;
        end
    end

    bsa_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_need_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr),
        .wdata (need_wd),
        .raddr (addr),
        .rdata (need_rd)
    );

    bsa_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_alloc_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr),
        .wdata (alloc_wd),
        .raddr (addr),
        .rdata (alloc_rd)
    );

    // free counts and request buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RESOURCES; i++)
            begin
                free_reg[i] <= '0;
                buf_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.wr_free)
            begin
                free_reg[item_r_reg] <= amt_reg;
            end
            else if (cmd.ld_commit)
            begin
                free_reg[item_r_reg] <= free_reg[item_r_reg] - amt_reg;
            end
            else if (cmd.grant_wr)
            begin
                free_reg[r_cnt_reg] <= free_r - buf_r;
            end
            else if (cmd.roll_wr)
            begin
                free_reg[r_cnt_reg] <= free_r + buf_r;
            end
            if (cmd.buf_clear)
            begin
                for (int i = 0; i < RESOURCES; i++)
                begin
                    buf_reg[i] <= '0;
                end
            end
            else if (cmd.buf_write)
            begin
                buf_reg[item_r_reg] <= amt_reg;
            end
        end
    end

    // safety scan
    logic [CB-1:0] work_reg [RESOURCES];
    logic [CB-1:0] tmp_reg  [RESOURCES];
    logic          fin_reg  [PROCESSES];
    logic [PW-1:0] seq_reg  [PROCESSES];
    logic          fits_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            for (int i = 0; i < RESOURCES; i++)
            begin
                work_reg[i] <= (i < int'(nr)) ? free_reg[i] : '0;
            end
            for (int i = 0; i < PROCESSES; i++)
            begin
                fin_reg[i] <= 1'b0;
            end
        end
        else if (cmd.row_commit)
        begin
            for (int i = 0; i < RESOURCES; i++)
            begin
                if (i < int'(nr))
                begin
                    work_reg[i] <= tmp_reg[i];
                end
            end
            fin_reg[p_cnt_reg]          <= 1'b1;
            seq_reg[k_reg[PW-1:0]]      <= p_cnt_reg;
        end
        if (cmd.row_start)
        begin
            fits_reg <= 1'b1;
        end
        else if (cmd.row_cmp)
        begin
            if (need_rd > work_reg[r_cnt_reg])
            begin
                fits_reg <= 1'b0;
            end
            tmp_reg[r_cnt_reg] <= sat_add(work_reg[r_cnt_reg], alloc_rd);
        end
    end

    // result register
    logic       out_valid_reg;
    logic [2:0] out_status_reg;
    logic [2:0] out_seq_reg;
    logic       out_end_reg;
    logic       out_space;

    assign out_space = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.seq_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            out_seq_reg    <= 3'd0;
            out_end_reg    <= 1'b1;
        end
        else if (cmd.seq_out)
        begin
            out_status_reg <= ST_OK;
            out_seq_reg    <= 3'(seq_reg[j_reg]);
            out_end_reg    <= sts.j_last;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = out_status_reg;
    assign result.sequence_process = out_seq_reg;
    assign result.end_of_run       = out_end_reg;

    always_comb
    begin
        sts.in_fire   = in_fire;
        sts.act       = act_reg;
        sts.p_ok      = p_ok_reg;
        sts.r_ok      = r_ok_reg;
        sts.last      = last_reg;
        sts.clr_done  = (32'(clr_cnt_reg) == DEPTH - 1);
        sts.r_last    = (RCW'(r_cnt_reg) + RCW'(1)) == nr;
        sts.p_last    = (PCW'(p_cnt_reg) + PCW'(1)) == np;
        sts.k_last    = (k_reg + PCW'(1)) == np;
        sts.fits      = fits_reg;
        sts.need_bad  = buf_r > need_rd;
        sts.avail_bad = buf_r > free_r;
        sts.ld_reject = (amt_reg > need_rd) || (amt_reg > free_reg[item_r_reg]);
        sts.fin_p     = fin_reg[p_cnt_reg];
        sts.j_last    = (PCW'(j_reg) + PCW'(1)) == np;
        sts.out_space = out_space;
    end
endmodule
`default_nettype wire

// ===== rtl/banker_safety_allocator.sv =====
// Banker's algorithm engine, one word at a time.
// Loads are written at decode (allocation loads first read and check the entry); a request
// element that is not last is buffered. Request decisions check need and free per resource,
// then grant per resource, then scan up to np*np rows; results stream 1/cycle unless result stalls.
// After reset, a clearing pass zeroes the need and allocation memories before the first
// word is taken; all counts reset to zero, config to 4 and 8.
`timescale 1ns / 1ps
`default_nettype none
module banker_safety_allocator #(
    parameter int RESOURCES  = bsa_pkg::RESOURCES_DEF,
    parameter int PROCESSES  = bsa_pkg::PROCESSES_DEF,
    parameter int COUNT_BITS = bsa_pkg::COUNT_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [3:0] cfg_data,
    bsa_in_if.sink          item,
    bsa_out_if.source       result
);
    import bsa_pkg::*;

    bsa_cmd_t cmd;
    bsa_sts_t sts;

    bsa_dp #(
        .RESOURCES  (RESOURCES),
        .PROCESSES  (PROCESSES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .result    (result),
        .cmd       (cmd),
        .sts       (sts)
    );

    bsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );
endmodule
`default_nettype wire
